@@ rtl/core/eprt_pkg.sv @@
// ----------------------------------------------------------------------------
// eprt_pkg
// Shared types and constants for the edge period rpm tracker.
// ----------------------------------------------------------------------------
package eprt_pkg;

  localparam int RATE_W = 32;

  // microseconds in one minute, sized for the product with ticks_per_us
  localparam int          PROD_W     = 34;
  localparam logic [PROD_W-1:0] US_PER_MIN = 34'd60000000;

  localparam logic [RATE_W-1:0] SAT32 = 32'hFFFF_FFFF;

  // register indexes on the configuration port
  localparam logic [1:0] REG_TICKS_PER_US = 2'd0;
  localparam logic [1:0] REG_MAX_RPM      = 2'd1;
  localparam logic [1:0] REG_MIN_RPM      = 2'd2;
  localparam logic [1:0] REG_RAW_MODE     = 2'd3;

  // opcodes of an input item
  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // result status codes
  localparam logic [2:0] ST_FIRST   = 3'd0;
  localparam logic [2:0] ST_ACCEPT  = 3'd1;
  localparam logic [2:0] ST_SHORT   = 3'd2;
  localparam logic [2:0] ST_BELOW   = 3'd3;
  localparam logic [2:0] ST_RAW_OUT = 3'd4;
  localparam logic [2:0] ST_RESTART = 3'd5;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] est;
    logic [RATE_W-1:0] rate;
  } upd_req_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] est;
  } upd_rsp_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/core/eprt_if.sv @@
// ----------------------------------------------------------------------------
// eprt channel interfaces
// Valid/ready channels for tachometer items and speed results.
// ----------------------------------------------------------------------------
interface eprt_in_if #(
  parameter int TIME_W = 32
);
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [TIME_W-1:0] edge_time;

  modport source (output valid, output opcode, output edge_time, input ready);
  modport sink   (input valid, input opcode, input edge_time, output ready);
endinterface

interface eprt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rpm_value;
  logic [31:0] period_ticks;
  logic        rotation_mark;
  logic [2:0]  status;

  modport source (output valid, output rpm_value, output period_ticks,
                  output rotation_mark, output status, input ready);
  modport sink   (input valid, input rpm_value, input period_ticks,
                  input rotation_mark, input status, output ready);
endinterface

@@ rtl/core/eprt_div.sv @@
// ----------------------------------------------------------------------------
// eprt_div
// Bit-serial restoring divider, one quotient bit per cycle, result
// saturated to 32 bits.
// ----------------------------------------------------------------------------
module eprt_div
  import eprt_pkg::*;
#(
  parameter int NUM_W = 42,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output div_rsp_t         rsp
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [RATE_W-1:0] q_r, q_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W:0]    shifted;
  logic              fits;

  assign shifted = {rem_r, num_r[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      rem_nxt  = '0;
      q_nxt    = '0;
      ovf_nxt  = 1'b0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      rem_nxt = fits ? DEN_W'(shifted - {1'b0, den_r}) : DEN_W'(shifted);
      q_nxt   = {q_r[RATE_W-2:0], fits};
      // any quotient bit pushed past bit 31 means saturation
      ovf_nxt = ovf_r | q_r[RATE_W-1];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  // zero divisor yields all ones in every bit, so it saturates as well
  assign rsp.done = done_r;
  assign rsp.quot = ovf_r ? SAT32 : q_r;

endmodule

@@ rtl/core/eprt_upd.sv @@
// ----------------------------------------------------------------------------
// eprt_upd
// Estimate update: jump on a large deviation or a zero estimate, otherwise
// an eighth-step move toward the new reading.
// ----------------------------------------------------------------------------
module eprt_upd
  import eprt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  upd_req_t req,
  output upd_rsp_t rsp
);

  logic [RATE_W-1:0] a_r, b_r, gap_r, res_r, res_nxt;
  logic [RATE_W:0]   sum_r;
  logic              up_r, zero_r, jump_r;
  logic [2:0]        st_r;
  logic              done_r;
  logic [RATE_W+4:0] gap20;
  logic [RATE_W-1:0] step;

  // 20 * gap as 16 * gap + 4 * gap
  assign gap20 = {1'b0, gap_r, 4'b0000} + {3'b000, gap_r, 2'b00};
  assign step  = gap_r >> 3;

  always_comb begin
    if (jump_r) begin
      res_nxt = b_r;
    end else if (up_r) begin
      res_nxt = a_r + step;
    end else begin
      res_nxt = a_r - step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= {st_r[1:0], req.start};
      done_r <= st_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.est;
      b_r <= req.rate;
    end
    if (st_r[0]) begin
      gap_r  <= (a_r > b_r) ? a_r - b_r : b_r - a_r;
      sum_r  <= {1'b0, a_r} + {1'b0, b_r};
      up_r   <= b_r >= a_r;
      zero_r <= a_r == '0;
    end
    if (st_r[1]) begin
      jump_r <= zero_r || (gap20 > (RATE_W+5)'(sum_r));
    end
    if (st_r[2]) begin
      res_r <= res_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.est  = res_r;

endmodule

@@ rtl/core/edge_period_rpm_tracker_top.sv @@
// ----------------------------------------------------------------------------
// edge_period_rpm_tracker_top
// Tachometer edge period to rpm estimate in unsigned fixed point, with
// short-pulse merging, range checks and a jump-or-smooth filter.
// ----------------------------------------------------------------------------
// channel | dir | handshake   | payload
// in_ch   | in  | valid/ready | opcode, edge_time
// out_ch  | out | valid/ready | rpm_value, period_ticks, rotation_mark, status
// cfg     | in  | cfg_we      | cfg_idx, cfg_wdata
//
// an edge with a prior edge goes from S_DEC through S_DEN and S_DIV to S_CHK,
// then to S_FIN when merged or below minimum, through S_UPD when filtered and
// through S_UPD and S_RCHK in raw mode; the divide runs in the bit-serial
// divider, one quotient bit a cycle
// restart and first edge items go from S_DEC straight to S_FIN
// one item is in flight at a time; a new item is taken while the previous
// result waits in the output register
// reset is synchronous; speed, carried span and last edge time clear to zero
// ----------------------------------------------------------------------------
module edge_period_rpm_tracker_top
  import eprt_pkg::*;
#(
  parameter int FRAC_BITS  = 8,
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  eprt_in_if.sink     in_ch,
  eprt_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [17:0] cfg_wdata
);

  localparam int TW    = TIME_WIDTH;
  localparam int DEN_W = ((TW > RATE_W) ? TW : RATE_W) + 1;
  localparam int NUM_W = PROD_W + FRAC_BITS;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DEC  = 8'b0000_0010,
    S_DEN  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_CHK  = 8'b0001_0000,
    S_UPD  = 8'b0010_0000,
    S_RCHK = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [7:0]  tpu_r;
  logic [17:0] max_rpm_r, min_rpm_r;
  logic        raw_r;

  // tracker state
  logic [TW-1:0]     last_r, last_nxt;
  logic              have_r, have_nxt;
  logic [RATE_W-1:0] carried_r, carried_nxt;
  logic [RATE_W-1:0] est_r, est_nxt;

  // item in flight
  logic              op_r;
  logic [TW-1:0]     t_r;
  logic [TW-1:0]     period_r, period_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic              mark_r, mark_nxt;
  logic [2:0]        status_r, status_nxt;

  // output register
  logic              ov_r, ov_nxt;
  logic [RATE_W-1:0] o_rpm_r;
  logic [31:0]       o_per_r;
  logic              o_mark_r;
  logic [2:0]        o_st_r;

  logic              in_xfer, out_free;
  logic [RATE_W-1:0] hi, lo;
  logic [DEN_W-1:0]  span;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  num;
  logic              div_start;
  div_rsp_t          div_rsp;
  upd_req_t          upd_req;
  upd_rsp_t          upd_rsp;

  assign in_ch.ready = state_r == S_IDLE;
  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign out_free    = !ov_r || out_ch.ready;

  assign hi   = RATE_W'(max_rpm_r) << FRAC_BITS;
  assign lo   = RATE_W'(min_rpm_r) << FRAC_BITS;
  assign span = DEN_W'(period_r) + DEN_W'(carried_r);
  assign prod = US_PER_MIN * PROD_W'(tpu_r);
  assign num  = NUM_W'(prod) << FRAC_BITS;

  assign div_start = state_r == S_DEN;

  eprt_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (span),
    .rsp   (div_rsp)
  );

  eprt_upd u_upd (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (upd_req),
    .rsp   (upd_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    have_nxt      = have_r;
    carried_nxt   = carried_r;
    est_nxt       = est_r;
    period_nxt    = period_r;
    rate_nxt      = rate_r;
    mark_nxt      = mark_r;
    status_nxt    = status_r;
    ov_nxt        = ov_r;
    upd_req.start = 1'b0;
    upd_req.est   = est_r;
    upd_req.rate  = rate_r;
    if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        mark_nxt = 1'b0;
        if (op_r == OP_RESTART) begin
          est_nxt     = '0;
          carried_nxt = '0;
          last_nxt    = '0;
          have_nxt    = 1'b0;
          period_nxt  = '0;
          status_nxt  = ST_RESTART;
          state_nxt   = S_FIN;
        end else if (!have_r) begin
          last_nxt    = t_r;
          have_nxt    = 1'b1;
          est_nxt     = '0;
          carried_nxt = '0;
          period_nxt  = '0;
          status_nxt  = ST_FIRST;
          state_nxt   = S_FIN;
        end else begin
          period_nxt = t_r - last_r;
          last_nxt   = t_r;
          state_nxt  = S_DEN;
        end
      end
      S_DEN: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          rate_nxt  = div_rsp.quot;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (raw_r) begin
          upd_req.start = 1'b1;
          state_nxt     = S_UPD;
        end else if (rate_r > hi) begin
          // too fast: fold this period into the carried span
          carried_nxt = (span > DEN_W'(SAT32)) ? SAT32 : RATE_W'(span);
          status_nxt  = ST_SHORT;
          state_nxt   = S_FIN;
        end else if (rate_r < lo) begin
          carried_nxt = '0;
          status_nxt  = ST_BELOW;
          state_nxt   = S_FIN;
        end else begin
          carried_nxt   = '0;
          upd_req.start = 1'b1;
          state_nxt     = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_rsp.done) begin
          est_nxt = upd_rsp.est;
          if (raw_r) begin
            state_nxt = S_RCHK;
          end else begin
            mark_nxt   = 1'b1;
            status_nxt = ST_ACCEPT;
            state_nxt  = S_FIN;
          end
        end
      end
      S_RCHK: begin
        if (est_r > hi || est_r < lo) begin
          status_nxt = ST_RAW_OUT;
        end else begin
          mark_nxt   = 1'b1;
          status_nxt = ST_ACCEPT;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ov_r      <= 1'b0;
      tpu_r     <= 8'd72;
      max_rpm_r <= 18'd10000;
      min_rpm_r <= 18'd60;
      raw_r     <= 1'b0;
      last_r    <= '0;
      have_r    <= 1'b0;
      carried_r <= '0;
      est_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      ov_r      <= ov_nxt;
      last_r    <= last_nxt;
      have_r    <= have_nxt;
      carried_r <= carried_nxt;
      est_r     <= est_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_TICKS_PER_US: tpu_r     <= cfg_wdata[7:0];
          REG_MAX_RPM:      max_rpm_r <= cfg_wdata;
          REG_MIN_RPM:      min_rpm_r <= cfg_wdata;
          REG_RAW_MODE:     raw_r     <= cfg_wdata[0];
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    period_r <= period_nxt;
    rate_r   <= rate_nxt;
    mark_r   <= mark_nxt;
    status_r <= status_nxt;
    if (in_xfer) begin
      op_r <= in_ch.opcode;
      t_r  <= in_ch.edge_time;
    end
    if (state_r == S_FIN && out_free) begin
      o_rpm_r  <= est_r;
      o_per_r  <= 32'(period_r);
      o_mark_r <= mark_r;
      o_st_r   <= status_r;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.rpm_value     = o_rpm_r;
  assign out_ch.period_ticks  = o_per_r;
  assign out_ch.rotation_mark = o_mark_r;
  assign out_ch.status        = o_st_r;

endmodule

@@ rtl/core/eprt_chk.sv @@
// ----------------------------------------------------------------------------
// eprt_chk
// Port-level checks for the edge period rpm tracker, bound to the top level.
// ----------------------------------------------------------------------------
module eprt_chk
  import eprt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] rpm_value,
  input logic [31:0] period_ticks,
  input logic        rotation_mark,
  input logic [2:0]  status
);

  // one item at a time: the input closes right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready straight after a transfer");

  // restart and first edge results carry no speed and no period
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status == ST_RESTART || status == ST_FIRST)) |->
      (rpm_value == '0 && period_ticks == '0 && !rotation_mark))
    else $error("restart or first edge result not cleared");

  // the revolution mark goes with the accepted status only
  a_mark_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (rotation_mark == (status == ST_ACCEPT)))
    else $error("rotation mark disagrees with status");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(rpm_value) && $stable(period_ticks) &&
       $stable(rotation_mark) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind edge_period_rpm_tracker_top eprt_chk u_eprt_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .rpm_value     (out_ch.rpm_value),
  .period_ticks  (out_ch.period_ticks),
  .rotation_mark (out_ch.rotation_mark),
  .status        (out_ch.status)
);

@@ test/edge_period_rpm_tracker_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_period_rpm_tracker_top_test
// Drives tachometer edges and restarts into the tracker under several register
// settings and compares every result against a cycle-free speed predictor.
// Covers wrap-around periods, short-pulse merging up to saturation, the range
// limits, the jump/smooth filter, raw mode and output back-pressure.
// ----------------------------------------------------------------------------
module edge_period_rpm_tracker_top_test;
  import eprt_pkg::*;

  localparam int FRAC_BITS    = 8;
  localparam int TIME_WIDTH   = 32;
  localparam int EDGE_LATENCY = 34 + FRAC_BITS + 9;

  typedef struct packed {
    logic [31:0] rpm_value;
    logic [31:0] period_ticks;
    logic        rotation_mark;
    logic [2:0]  status;
  } speed_result_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_kind_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [17:0] cfg_wdata;

  eprt_in_if #(.TIME_W(TIME_WIDTH)) in_ch ();
  eprt_out_if                       out_ch ();

  edge_period_rpm_tracker_top #(
    .FRAC_BITS  (FRAC_BITS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // register mirror
  logic [7:0]  tpu_cfg = 8'd72;
  logic [17:0] max_cfg = 18'd10000;
  logic [17:0] min_cfg = 18'd60;
  logic        raw_cfg = 1'b0;

  // tracker state as the predictor sees it
  logic [31:0] last_edge_seen = '0;
  logic        have_edge_seen = 1'b0;
  logic [31:0] carried_span   = '0;
  logic [31:0] speed_est      = '0;

  speed_result_t pending_speed_results[$];

  // stimulus state
  logic [31:0] edge_clock;
  logic [31:0] cur_period;
  logic [31:0] pending_rest;
  logic        need_first;
  int          burst_left;
  bit          gaps_on;
  stall_kind_t stall_mode;
  int          hold_req;
  int          hold_left;
  int          pattern_step;

  int fail_count;
  int items_sent;
  int results_seen;
  int reg_writes;
  int settings_run;
  int status_seen [0:7];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $error("timed out with %0d results outstanding", pending_speed_results.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] instant_rate(input logic [31:0] period);
    logic [63:0] denom;
    logic [63:0] num;
    logic [63:0] quot;
    denom = {32'd0, period} + {32'd0, carried_span};
    num   = (64'(US_PER_MIN) * 64'(tpu_cfg)) << FRAC_BITS;
    if (denom == 64'd0) return SAT32;
    quot = num / denom;
    return (quot > 64'(SAT32)) ? SAT32 : quot[31:0];
  endfunction

  function automatic void smooth_toward(input logic [31:0] rate);
    logic [63:0] est;
    logic [63:0] gap;
    est = 64'(speed_est);
    gap = (est > 64'(rate)) ? est - 64'(rate) : 64'(rate) - est;
    if (est == 64'd0 || 64'd20 * gap > est + 64'(rate))
      speed_est = rate;
    else if (rate >= speed_est)
      speed_est = speed_est + 32'(gap >> 3);
    else
      speed_est = speed_est - 32'(gap >> 3);
  endfunction

  function automatic speed_result_t track_speed(input logic op, input logic [31:0] t);
    speed_result_t res;
    logic [31:0]   rate;
    logic [63:0]   hi;
    logic [63:0]   lo;
    logic [63:0]   sum;
    res = '0;
    hi  = 64'(max_cfg) << FRAC_BITS;
    lo  = 64'(min_cfg) << FRAC_BITS;
    if (op == OP_RESTART) begin
      speed_est      = '0;
      carried_span   = '0;
      last_edge_seen = '0;
      have_edge_seen = 1'b0;
      res.status     = ST_RESTART;
    end else if (!have_edge_seen) begin
      last_edge_seen = t;
      have_edge_seen = 1'b1;
      speed_est      = '0;
      carried_span   = '0;
      res.status     = ST_FIRST;
    end else begin
      res.period_ticks = t - last_edge_seen;
      last_edge_seen   = t;
      rate             = instant_rate(res.period_ticks);
      if (raw_cfg) begin
        // raw mode filters first and range-checks the filtered value
        smooth_toward(rate);
        if (64'(speed_est) > hi || 64'(speed_est) < lo) begin
          res.status = ST_RAW_OUT;
        end else begin
          res.status        = ST_ACCEPT;
          res.rotation_mark = 1'b1;
        end
      end else if (64'(rate) > hi) begin
        sum          = 64'(carried_span) + 64'(res.period_ticks);
        carried_span = (sum > 64'(SAT32)) ? SAT32 : sum[31:0];
        res.status   = ST_SHORT;
      end else begin
        carried_span = '0;
        if (64'(rate) < lo) begin
          res.status = ST_BELOW;
        end else begin
          smooth_toward(rate);
          res.status        = ST_ACCEPT;
          res.rotation_mark = 1'b1;
        end
      end
    end
    res.rpm_value = speed_est;
    return res;
  endfunction

  // ---------------------------------------------------------------- result side

  always @(negedge clk) begin
    pattern_step++;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_NONE:   out_ch.ready <= 1'b1;
        STALL_RANDOM: out_ch.ready <= ($urandom_range(0, 99) >= 30);
        default:      out_ch.ready <= ((pattern_step % 13) < 9) && ((pattern_step % 5) != 2);
      endcase
    end
  end

  always @(posedge clk) begin
    speed_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_speed_results.size() == 0) begin
        $error("unexpected result: rpm_value %0h status %0d", out_ch.rpm_value, out_ch.status);
        fail_count++;
      end else begin
        want = pending_speed_results.pop_front();
        status_seen[want.status]++;
        if (out_ch.rpm_value !== want.rpm_value) begin
          $error("rpm_value: expected %0h, got %0h", want.rpm_value, out_ch.rpm_value);
          fail_count++;
        end
        if (out_ch.period_ticks !== want.period_ticks) begin
          $error("period_ticks: expected %0h, got %0h", want.period_ticks,
                 out_ch.period_ticks);
          fail_count++;
        end
        if (out_ch.rotation_mark !== want.rotation_mark) begin
          $error("rotation_mark: expected %0b, got %0b", want.rotation_mark,
                 out_ch.rotation_mark);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- shared tasks

  // valid stays up across back-to-back items; gaps, when enabled, open between bursts
  task automatic send_item(input logic op, input logic [31:0] t);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.edge_time <= t;
    do @(posedge clk); while (!in_ch.ready);
    pending_speed_results.push_back(track_speed(op, t));
    items_sent++;
  endtask

  task automatic advance_edge(input logic [31:0] period);
    edge_clock = edge_clock + period;
    send_item(OP_EDGE, edge_clock);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_speed_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [17:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TICKS_PER_US: tpu_cfg = data[7:0];
      REG_MAX_RPM:      max_cfg = data;
      REG_MIN_RPM:      min_cfg = data;
      REG_RAW_MODE:     raw_cfg = data[0];
    endcase
    reg_writes++;
  endtask

  // log-spread speed around the plausible band, turned into a period
  function automatic logic [31:0] pick_base_period();
    real lo_r;
    real hi_r;
    real u;
    real rpm_r;
    real per_r;
    lo_r = (min_cfg == 0) ? 1.0 : real'(min_cfg);
    hi_r = (max_cfg == 0) ? 1.0 : real'(max_cfg);
    if (hi_r < lo_r) hi_r = lo_r;
    lo_r  = lo_r * 0.8;
    hi_r  = hi_r * 1.2;
    u     = $urandom_range(0, 10000) / 10000.0;
    rpm_r = $exp($ln(lo_r) + u * ($ln(hi_r) - $ln(lo_r)));
    per_r = 60.0e6 * real'(tpu_cfg) / rpm_r;
    if (per_r >= 4294967295.0) return 32'hFFFF_FFFF;
    if (per_r < 1.0) return 32'd1;
    return 32'(longint'(per_r));
  endfunction

  function automatic logic [31:0] next_period();
    longint unsigned p;
    longint unsigned part;
    int              pick;
    if (pending_rest != 0) begin
      p            = pending_rest;
      pending_rest = '0;
      return 32'(p);
    end
    // slow drift of the underlying speed
    p = (longint'(cur_period) * (980 + $urandom_range(0, 40))) / 1000;
    cur_period = (p == 0) ? 32'd1 : (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(p);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      p = (longint'(cur_period) * (950 + $urandom_range(0, 100))) / 1000;
    end else if (pick < 72) begin
      p = (longint'(cur_period) * $urandom_range(500, 1800)) / 1000;
    end else if (pick < 84) begin
      // short pulse, the rest of the revolution follows
      part         = longint'(cur_period) / $urandom_range(2, 12);
      p            = part;
      pending_rest = 32'(longint'(cur_period) - part);
    end else if (pick < 92) begin
      p = longint'(cur_period) * $urandom_range(3, 60);
    end else if (pick < 96) begin
      cur_period = pick_base_period();
      p          = cur_period;
    end else begin
      p = $urandom_range(0, 3000);
    end
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(p);
  endfunction

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      send_item(OP_RESTART, $urandom());
      need_first = 1'b1;
    end else if (need_first || pick < 5) begin
      edge_clock = $urandom();
      need_first = 1'b0;
      send_item(OP_EDGE, edge_clock);
    end else begin
      advance_edge(next_period());
    end
  endtask

  task automatic run_traffic_phase(input logic [7:0] tpu, input logic [17:0] max_rpm,
                                   input logic [17:0] min_rpm, input logic raw,
                                   input int count, input stall_kind_t stall,
                                   input bit gaps, input int hold_cycles);
    wait_results_drained();
    write_reg(REG_TICKS_PER_US, {10'd0, tpu});
    write_reg(REG_MAX_RPM, max_rpm);
    write_reg(REG_MIN_RPM, min_rpm);
    write_reg(REG_RAW_MODE, {17'd0, raw});
    settings_run++;
    stall_mode   = stall;
    gaps_on      = gaps;
    cur_period   = pick_base_period();
    pending_rest = '0;
    if (hold_cycles > 0) hold_req = hold_cycles;
    repeat (count) send_random_item();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_edges();
    stall_mode = STALL_RANDOM;
    gaps_on    = 1'b1;
    // first edge just below the wrap point, next one wraps
    edge_clock = 32'hFFFF_FF00;
    send_item(OP_EDGE, edge_clock);
    advance_edge(32'd432000);      // exactly at max speed
    advance_edge(32'd431999);      // just too fast, merged
    advance_edge(32'd400000);      // accepted with the carried span
    advance_edge(32'd850000);
    advance_edge(32'd860000);      // within 10 percent, smoothed
    advance_edge(32'd1500000);     // far off, jumps
    advance_edge(32'd72000000);    // exactly at min speed
    advance_edge(32'd72000001);    // just too slow
    advance_edge(32'd0);           // zero period saturates the rate, merged
    advance_edge(32'hFFFF_FFFF);   // longest wrapping period
    send_item(OP_RESTART, 32'hFFFF_FFFF);
    edge_clock = 32'd0;
    send_item(OP_EDGE, edge_clock);
    send_item(OP_RESTART, 32'd0);
  endtask

  task automatic test_register_extremes();
    wait_results_drained();
    // upper data bits must be dropped
    write_reg(REG_TICKS_PER_US, 18'h3_A5FF);
    write_reg(REG_MAX_RPM, 18'd0);
    write_reg(REG_MIN_RPM, 18'd0);
    settings_run++;
    edge_clock = 32'h1234_5678;
    send_item(OP_EDGE, edge_clock);
    // every edge merges; the carried span runs into saturation
    advance_edge(32'hC000_0000);
    advance_edge(32'hC000_0000);
    advance_edge(32'hFFFF_FFFF);
    wait_results_drained();
    write_reg(REG_MAX_RPM, 18'd200000);
    write_reg(REG_MIN_RPM, 18'd200000);
    settings_run++;
    advance_edge(32'd10);          // denominator past 32 bits, below minimum
    advance_edge(32'd5);           // saturated speed, merged
    wait_results_drained();
    write_reg(REG_RAW_MODE, 18'h2_0001);
    write_reg(REG_MIN_RPM, 18'd0);
    settings_run++;
    advance_edge(32'd3);           // raw, saturated estimate out of range
    advance_edge(32'd100000000);
    wait_results_drained();
    write_reg(REG_MIN_RPM, 18'd200000);
    settings_run++;
    advance_edge(32'd100000000);   // raw, estimate below minimum
    wait_results_drained();
    write_reg(REG_MIN_RPM, 18'd100);
    write_reg(REG_MAX_RPM, 18'd100);
    settings_run++;
    advance_edge(32'd152999995);   // lands exactly on the single allowed speed
  endtask

  task automatic test_normal_mode_traffic();
    run_traffic_phase(8'd72, 18'd10000, 18'd60, 1'b0, 165, STALL_RANDOM, 1'b1, 0);
    run_traffic_phase(8'd255, 18'd200000, 18'd0, 1'b0, 165, STALL_NONE, 1'b0, 0);
    run_traffic_phase(8'($urandom_range(1, 255)), 18'($urandom_range(1000, 200000)),
                      18'($urandom_range(0, 800)), 1'b0, 165, STALL_PATTERN, 1'b1, 0);
  endtask

  task automatic test_raw_mode_traffic();
    run_traffic_phase(8'd72, 18'd10000, 18'd60, 1'b1, 165, STALL_PATTERN, 1'b1, 0);
    run_traffic_phase(8'd1, 18'd200000, 18'd0, 1'b1, 165, STALL_RANDOM, 1'b1, 0);
    run_traffic_phase(8'($urandom_range(1, 255)), 18'($urandom_range(2000, 200000)),
                      18'($urandom_range(500, 2000)), 1'b1, 165, STALL_RANDOM, 1'b0, 0);
  endtask

  // receiver holds off for a long stretch while edges keep coming
  task automatic test_output_backpressure();
    run_traffic_phase(8'd100, 18'd30000, 18'd100, 1'b0, 80, STALL_NONE, 1'b0, 300);
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_TICKS_PER_US;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_EDGE;
    in_ch.edge_time = '0;
    out_ch.ready    = 1'b0;
    need_first      = 1'b1;
    burst_left      = 0;
    gaps_on         = 1'b0;
    stall_mode      = STALL_NONE;
    hold_req        = 0;
    hold_left       = 0;
    pattern_step    = 0;
    fail_count      = 0;
    items_sent      = 0;
    results_seen    = 0;
    reg_writes      = 0;
    settings_run    = 1;
    edge_clock      = '0;
    cur_period      = 32'd432000;
    pending_rest    = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_register_extremes();
    test_normal_mode_traffic();
    test_raw_mode_traffic();
    test_output_backpressure();

    wait_results_drained();
    repeat (EDGE_LATENCY + 10) @(posedge clk);
    $display("%0d items in, %0d results checked over %0d settings and %0d register writes",
             items_sent, results_seen, settings_run, reg_writes);
    $display("results by kind: first %0d, accepted %0d, merged %0d, below %0d, raw out %0d, restart %0d",
             status_seen[ST_FIRST], status_seen[ST_ACCEPT], status_seen[ST_SHORT],
             status_seen[ST_BELOW], status_seen[ST_RAW_OUT], status_seen[ST_RESTART]);
    if (fail_count == 0 && pending_speed_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
